### sv/lcddith_pkg.sv
// Shared constants, register indexes and the dither mapping function for the
// 2bpp-to-1bpp dithering scaler. No dependencies.
package lcddith_pkg;

    // Source geometry and framebuffer stride
    localparam int SRC_ROWS      = 144;
    localparam int FB_ROW_STRIDE = 52;

    // Last valid source row, used for clamping
    localparam logic [7:0] SRC_LAST_ROW = 8'(SRC_ROWS - 1);

    // Divide-by-3 of an 8-bit value: (n * 171) >> 9 is exact for n < 256
    localparam logic [7:0] DIV3_RECIP = 8'd171;
    localparam int         DIV3_SHIFT = 9;

    // Configuration register reset values
    localparam logic [15:0] DITHER_RESET = 16'h0B1F;
    localparam logic [7:0]  BOTTOM_RESET = 8'd240;
    localparam logic [5:0]  LEFT_RESET   = 6'd5;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_DITHER_TABLE = 2'd0,
        REG_BOTTOM_ROW   = 2'd1,
        REG_LEFT_OFFSET  = 2'd2,
        REG_UNUSED       = 2'd3
    } cfg_reg_t;

    // Map four 2-bit gray pixels through a pattern; the first pixel (low bits)
    // lands in bits 7:6 of the result
    function automatic logic [7:0] map_byte(input logic [7:0] pix, input logic [7:0] pattern);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < 4; i++) begin
            acc[7 - 2*i -: 2] = pattern[{pix[2*i +: 2], 1'b0} +: 2];
        end
        return acc;
    endfunction

endpackage

### sv/lcd_2bpp_to_dithered_1bpp.sv
// Top level of the 2bpp-to-1bpp ordered-dither converter with 2,2,1 vertical
// scaling. Uses lcddith_pkg for constants, register indexes and map_byte.
//
// Usage:
//   Request channel: drive start high with pixel_byte, source_row,
//   byte_column and frame_parity. A request is taken at every rising edge
//   with start high and busy low; busy is always low, so one request can be
//   taken every cycle (throughput 1 item per cycle).
//   Result channel: done pulses for exactly one cycle with all result ports
//   valid once the request leaves stage 3. Results leave in request order.
//   The receiver cannot stall, so nothing ever backs up inside the block.
//   Pipeline: stage 1 clamps the row, forms the bottom-up index k, the skip
//   bit and (k + 1) / 3, and dithers the byte; stage 2 forms the row span and
//   top row; stage 3 forms the framebuffer address and the result registers.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
//   register (0 dither_table, 1 bottom_row, 2 left_byte_offset); index 3
//   is ignored. cfg_ready is always high. Write only while no request is in
//   flight.
//   Reset (rst_n low, asynchronous): pipeline empties, done drops and the
//   registers return to 0x0B1F, 240 and 5.
module lcd_2bpp_to_dithered_1bpp
    import lcddith_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // Request channel
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  pixel_byte,
    input  logic [7:0]  source_row,
    input  logic [5:0]  byte_column,
    input  logic        frame_parity,

    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    // Result channel
    output logic        done,
    output logic        row_skipped,
    output logic [13:0] fb_address,
    output logic [7:0]  first_byte,
    output logic [7:0]  second_byte,
    output logic        double_row,
    output logic [7:0]  first_row,
    output logic [7:0]  last_row
);

    // Configuration registers
    logic [15:0] dither_reg;
    logic [7:0]  bottom_reg;
    logic [5:0]  left_reg;

    // Stage 1 registers
    logic        s1_valid_reg;
    logic        s1_skip_reg;
    logic [7:0]  s1_n_reg;
    logic [6:0]  s1_q_reg;
    logic [7:0]  s1_byte0_reg;
    logic [7:0]  s1_byte1_reg;
    logic [5:0]  s1_col_reg;

    // Stage 2 registers
    logic        s2_valid_reg;
    logic        s2_skip_reg;
    logic        s2_dbl_reg;
    logic [13:0] s2_top_reg;
    logic [7:0]  s2_byte0_reg;
    logic [7:0]  s2_byte1_reg;
    logic [5:0]  s2_col_reg;

    // Result registers
    logic        done_reg;
    logic        skip_reg;
    logic [13:0] addr_reg;
    logic [7:0]  byte0_reg;
    logic [7:0]  byte1_reg;
    logic        dbl_reg;
    logic [7:0]  first_reg;
    logic [7:0]  last_reg;

    // Stage 1 combinational values
    logic [7:0]  s1_row_next;
    logic [7:0]  s1_k_next;
    logic [7:0]  s1_n_next;
    logic [15:0] s1_prod_next;
    logic [6:0]  s1_q_next;
    logic        s1_skip_next;

    // Stage 2 combinational values
    logic [1:0]  s2_r_next;
    logic [8:0]  s2_span_next;
    logic [13:0] s2_top_next;
    logic        s2_dbl_next;

    // Stage 3 combinational values
    logic [13:0] addr_next;
    logic [7:0]  last_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dither_reg <= DITHER_RESET;
            bottom_reg <= BOTTOM_RESET;
            left_reg   <= LEFT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DITHER_TABLE: dither_reg <= cfg_data;
                REG_BOTTOM_ROW:   bottom_reg <= cfg_data[7:0];
                REG_LEFT_OFFSET:  left_reg   <= cfg_data[5:0];
                default:          ;
            endcase
        end
    end

    // Stage 1: clamp row, bottom-up index, interlace test, divide by 3
    always_comb
    begin
        s1_row_next  = (source_row > SRC_LAST_ROW) ? SRC_LAST_ROW : source_row;
        s1_k_next    = SRC_LAST_ROW - s1_row_next;
        s1_n_next    = s1_k_next + 8'd1;
        s1_prod_next = 16'(s1_n_next) * 16'(DIV3_RECIP);
        s1_q_next    = s1_prod_next[DIV3_SHIFT +: 7];
        s1_skip_next = frame_parity ^ s1_k_next[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s1_skip_reg  <= s1_skip_next;
            s1_n_reg     <= s1_n_next;
            s1_q_reg     <= s1_q_next;
            s1_byte0_reg <= map_byte(pixel_byte, dither_reg[7:0]);
            s1_byte1_reg <= map_byte(pixel_byte, dither_reg[15:8]);
            s1_col_reg   <= byte_column;
        end
    end

    // Stage 2: remainder, double-row flag, scaled span and top framebuffer row
    always_comb
    begin
        s2_r_next    = 2'(s1_n_reg - 8'(3 * s1_q_reg));
        s2_span_next = 9'(5 * s1_q_reg) + 9'({s2_r_next, 1'b0});
        s2_top_next  = 14'(bottom_reg) - 14'(s2_span_next);
        s2_dbl_next  = (s2_r_next != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_skip_reg  <= s1_skip_reg;
            s2_dbl_reg   <= s2_dbl_next;
            s2_top_reg   <= s2_top_next;
            s2_byte0_reg <= s1_byte0_reg;
            s2_byte1_reg <= s1_byte1_reg;
            s2_col_reg   <= s1_col_reg;
        end
    end

    // Stage 3: framebuffer address and last row
    always_comb
    begin
        addr_next = 14'(left_reg) + 14'(s2_top_reg * 14'(FB_ROW_STRIDE)) + 14'(s2_col_reg);
        last_next = s2_top_reg[7:0] + 8'(s2_dbl_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s2_valid_reg;
    end

    // Register the results; drop all fields of a skipped row to zero
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            skip_reg <= s2_skip_reg;
            if (s2_skip_reg)
            begin
                addr_reg  <= '0;
                byte0_reg <= '0;
                byte1_reg <= '0;
                dbl_reg   <= 1'b0;
                first_reg <= '0;
                last_reg  <= '0;
            end
            else
            begin
                addr_reg  <= addr_next;
                byte0_reg <= s2_byte0_reg;
                byte1_reg <= s2_dbl_reg ? s2_byte1_reg : 8'd0;
                dbl_reg   <= s2_dbl_reg;
                first_reg <= s2_top_reg[7:0];
                last_reg  <= last_next;
            end
        end
    end

    assign done        = done_reg;
    assign row_skipped = skip_reg;
    assign fb_address  = addr_reg;
    assign first_byte  = byte0_reg;
    assign second_byte = byte1_reg;
    assign double_row  = dbl_reg;
    assign first_row   = first_reg;
    assign last_row    = last_reg;

    // Every request yields exactly one result strobe at the end of the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result strobe missing for a request");

    // A result strobe always traces back to a request
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 3))
        else $error("result strobe without a request");

    // Skipped rows carry all-zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && row_skipped) |-> (fb_address == 14'd0 && first_byte == 8'd0 &&
            second_byte == 8'd0 && !double_row && first_row == 8'd0 && last_row == 8'd0))
        else $error("skipped row with nonzero fields");

    // Row span agrees with the double-row flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !row_skipped) |-> (last_row == first_row + 8'(double_row) &&
            (double_row || second_byte == 8'd0)))
        else $error("row span inconsistent with double_row");

endmodule

### sim/lcd_2bpp_to_dithered_1bpp_tb.sv
// Self-checking testbench for the 2bpp-to-1bpp dithering scaler: directed and random
// requests against a behavioral predictor, checked field by field as results arrive.
// Depends on lcddith_pkg and lcd_2bpp_to_dithered_1bpp.
module lcd_2bpp_to_dithered_1bpp_tb
    import lcddith_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Expected content of one result strobe
    typedef struct packed {
        logic        row_skipped;
        logic [13:0] fb_address;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic        double_row;
        logic [7:0]  first_row;
        logic [7:0]  last_row;
    } dither_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  pixel_byte;
    logic [7:0]  source_row;
    logic [5:0]  byte_column;
    logic        frame_parity;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        done;
    logic        row_skipped;
    logic [13:0] fb_address;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic        double_row;
    logic [7:0]  first_row;
    logic [7:0]  last_row;

    // Register shadows tracked by the predictor
    logic [15:0] dither_cfg;
    logic [7:0]  bottom_cfg;
    logic [5:0]  left_cfg;

    dither_result_t pending_results[$];
    int unsigned    error_count;
    int unsigned    requests_sent;
    int unsigned    results_checked;
    int unsigned    skipped_seen;
    int unsigned    writes_done;
    bit             gapless_burst;

    lcd_2bpp_to_dithered_1bpp i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pixel_byte   (pixel_byte),
        .source_row   (source_row),
        .byte_column  (byte_column),
        .frame_parity (frame_parity),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .row_skipped  (row_skipped),
        .fb_address   (fb_address),
        .first_byte   (first_byte),
        .second_byte  (second_byte),
        .double_row   (double_row),
        .first_row    (first_row),
        .last_row     (last_row)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Map four gray pixels through one pattern row, first pixel into bits 7:6
    function automatic logic [7:0] dither_pixels(input logic [7:0] pix,
                                                 input logic [7:0] pattern);
        logic [7:0] acc;
        logic [7:0] rest;
        acc  = '0;
        rest = pix;
        for (int i = 0; i < 4; i++)
        begin
            acc  = {acc[5:0], 2'(pattern >> (2 * rest[1:0]))};
            rest = rest >> 2;
        end
        return acc;
    endfunction

    // Work out the framebuffer update for one source byte under the current registers
    function automatic dither_result_t predict_update(input logic [7:0] pix,
                                                      input logic [7:0] row,
                                                      input logic [5:0] col,
                                                      input logic       parity);
        dither_result_t r;
        logic [7:0]     clamped;
        int unsigned    k;
        int unsigned    rows_up;
        int unsigned    span;
        int unsigned    top;
        logic           dbl;
        r       = '0;
        clamped = (row > SRC_LAST_ROW) ? SRC_LAST_ROW : row;
        k       = SRC_ROWS - 1 - clamped;
        if (((k + parity) & 1) != 0)
        begin
            r.row_skipped = 1'b1;
            return r;
        end
        dbl     = (k % 3) != 2;
        rows_up = k + 1;
        span    = 5 * (rows_up / 3) + 2 * (rows_up % 3);
        top     = bottom_cfg - span;
        r.fb_address  = 14'(left_cfg + top * FB_ROW_STRIDE + col);
        r.first_byte  = dither_pixels(pix, dither_cfg[7:0]);
        r.second_byte = dbl ? dither_pixels(pix, dither_cfg[15:8]) : 8'd0;
        r.double_row  = dbl;
        r.first_row   = top[7:0];
        r.last_row    = 8'(top + dbl);
        return r;
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // Check every result strobe against the oldest pending prediction
    always @(posedge clk)
    begin
        dither_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result strobe with no request outstanding");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("row_skipped", want.row_skipped, row_skipped);
                compare_field("fb_address", want.fb_address, fb_address);
                compare_field("first_byte", want.first_byte, first_byte);
                compare_field("second_byte", want.second_byte, second_byte);
                compare_field("double_row", want.double_row, double_row);
                compare_field("first_row", want.first_row, first_row);
                compare_field("last_row", want.last_row, last_row);
                results_checked++;
                if (want.row_skipped)
                    skipped_seen++;
            end
        end
    end

    // Idle length between requests: mostly none, some short, a few long
    function automatic int unsigned idle_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (gapless_burst || roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // Present one request, hold it until taken, record its prediction, then idle for a random gap
    task automatic send_request(input logic [7:0] pix, input logic [7:0] row,
                                input logic [5:0] col, input logic parity);
        int unsigned gap;
        start        <= 1'b1;
        pixel_byte   <= pix;
        source_row   <= row;
        byte_column  <= col;
        frame_parity <= parity;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(predict_update(pix, row, col, parity));
        requests_sent++;
        gap = idle_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start and wait until every outstanding request has produced its result
    task automatic drain_requests();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Write one register, update the predictor's shadow, then idle the channel
    task automatic write_register(input cfg_reg_t idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_DITHER_TABLE: dither_cfg = data;
            REG_BOTTOM_ROW:   bottom_cfg = data[7:0];
            REG_LEFT_OFFSET:  left_cfg   = data[5:0];
            default:          ;
        endcase
        writes_done++;
        @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] dither, input logic [7:0] bottom,
                             input logic [5:0] left);
        drain_requests();
        write_register(REG_DITHER_TABLE, dither);
        write_register(REG_BOTTOM_ROW, {8'd0, bottom});
        write_register(REG_LEFT_OFFSET, {10'd0, left});
    endtask

    // Reset register values: every row-height phase, both parities, clamped rows,
    // out-of-range columns and the topmost row
    task automatic test_row_geometry();
        send_request(8'h00, 8'd143, 6'd0, 1'b0);
        send_request(8'hFF, 8'd142, 6'd39, 1'b1);
        send_request(8'h1B, 8'd141, 6'd0, 1'b0);
        send_request(8'hE4, 8'd141, 6'd1, 1'b1);
        send_request(8'h55, 8'd0, 6'd20, 1'b1);
        send_request(8'hAA, 8'd0, 6'd20, 1'b0);
        send_request(8'h3C, 8'd144, 6'd5, 1'b0);
        send_request(8'hC3, 8'd255, 6'd63, 1'b0);
        send_request(8'h96, 8'd100, 6'd40, 1'b1);
        drain_requests();
    endtask

    // Register extremes: all-zero and all-one patterns, wrap above the framebuffer top,
    // widest offsets, and a write to the unused index that must change nothing
    task automatic test_register_extremes();
        configure(16'h0000, 8'd0, 6'd0);
        send_request(8'hFF, 8'd143, 6'd0, 1'b0);
        send_request(8'h5A, 8'd0, 6'd63, 1'b1);
        configure(16'hFFFF, 8'd255, 6'd63);
        send_request(8'h00, 8'd143, 6'd39, 1'b0);
        send_request(8'hA5, 8'd1, 6'd63, 1'b0);
        configure(16'h1BE4, 8'd240, 6'd51);
        send_request(8'hE4, 8'd139, 6'd17, 1'b0);
        send_request(8'h1B, 8'd138, 6'd38, 1'b1);
        drain_requests();
        write_register(REG_UNUSED, 16'hFFFF);
        send_request(8'h6C, 8'd72, 6'd12, 1'b1);
        drain_requests();
    endtask

    // Random register settings, each followed by a run of random requests;
    // mostly in-range rows and columns, some clamped rows and wide columns
    task automatic test_random_traffic();
        logic [7:0] row;
        logic [5:0] col;
        for (int phase = 0; phase < 5; phase++)
        begin
            configure(16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255)),
                      ($urandom_range(0, 9) == 0) ? 6'($urandom_range(52, 63))
                                                  : 6'($urandom_range(0, 51)));
            for (int n = 0; n < 107; n++)
            begin
                // Every 30 requests, randomly choose a gapless run or a run with gaps
                if (n % 30 == 0)
                    gapless_burst = ($urandom_range(0, 2) == 0);
                row = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(144, 255))
                                                  : 8'($urandom_range(0, 143));
                col = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(40, 63))
                                                  : 6'($urandom_range(0, 39));
                send_request(8'($urandom_range(0, 255)), row, col, 1'($urandom()));
            end
            gapless_burst = 1'b0;
        end
        drain_requests();
    endtask

    initial
    begin
        int unsigned guard;
        rst_n         <= 1'b0;
        start         <= 1'b0;
        pixel_byte    <= '0;
        source_row    <= '0;
        byte_column   <= '0;
        frame_parity  <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_DITHER_TABLE;
        cfg_data      <= '0;
        dither_cfg    = DITHER_RESET;
        bottom_cfg    = BOTTOM_RESET;
        left_cfg      = LEFT_RESET;
        error_count   = 0;
        requests_sent = 0;
        results_checked = 0;
        skipped_seen  = 0;
        writes_done   = 0;
        gapless_burst = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_row_geometry();
        test_register_extremes();
        test_random_traffic();

        // Wait for stragglers, then keep watching for stray strobes
        start <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
        end

        $display("Sent %0d requests across %0d register writes; checked %0d results",
                 requests_sent, writes_done, results_checked);
        $display("(%0d interlace-skipped rows), %0d errors", skipped_seen, error_count);
        if (error_count == 0)
            $display("[lcd_2bpp_to_dithered_1bpp] OK");
        else
            $display("[lcd_2bpp_to_dithered_1bpp] ERROR");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #5_000_000;
        $display("timeout: run did not finish");
        $display("[lcd_2bpp_to_dithered_1bpp] ERROR");
        $finish;
    end

endmodule

### files.f
sv/lcddith_pkg.sv
sv/lcd_2bpp_to_dithered_1bpp.sv
sim/lcd_2bpp_to_dithered_1bpp_tb.sv
